### hdl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// types and constants shared by the oscillator bank evaluator
// ----------------------------------------------------------------------------
package sbe_pkg;

    localparam int AMP_W = 16;
    localparam int PH_W  = 32;
    localparam int SUM_W = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } stat_t;

endpackage

### hdl/sbe_datapath.sv
// ----------------------------------------------------------------------------
// sbe_datapath
// oscillator table, pipelined phase, sine, product and accumulator
// ----------------------------------------------------------------------------
module sbe_datapath #(
    parameter int IDX_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic signed [sbe_pkg::AMP_W-1:0] wr_amp,
    input  logic [sbe_pkg::PH_W-1:0]      wr_freq,
    input  logic [sbe_pkg::PH_W-1:0]      wr_phase,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic [sbe_pkg::PH_W-1:0]      sample_time,
    input  sbe_pkg::cmd_t                 cmd,
    output sbe_pkg::stat_t                stat,
    output logic signed [sbe_pkg::SUM_W-1:0] sum_value
);

    localparam int DEPTH = 1 << IDX_W;
    localparam int LAT   = 7;

    logic signed [sbe_pkg::AMP_W-1:0] amp_mem [DEPTH];
    logic [sbe_pkg::PH_W-1:0] freq_mem [DEPTH];
    logic [sbe_pkg::PH_W-1:0] ph_mem [DEPTH];

    logic [LAT-1:0] vld_reg;
    logic [sbe_pkg::PH_W-1:0] f1_reg, p1_reg, t_reg, pr2_reg, ph3_reg;
    logic [sbe_pkg::PH_W-1:0] p1_d_reg;
    logic signed [sbe_pkg::AMP_W-1:0] a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    logic [1:0] q4_reg, q5_reg, q6_reg;
    logic [14:0] z4_reg, z5_reg;
    logic [15:0] z2_5_reg;
    logic [15:0] r6_reg;
    logic [14:0] z6_reg;
    logic [15:0] s7_reg;
    logic [1:0] q7_reg;
    logic signed [sbe_pkg::AMP_W-1:0] a7_reg;
    logic signed [31:0] prod_reg;
    logic prod_vld_reg;
    logic signed [sbe_pkg::SUM_W-1:0] acc_reg;

    logic [15:0] u3;
    logic [13:0] x3;
    logic [14:0] zc;
    logic [29:0] zz;
    logic [31:0] t1;
    logic [15:0] rr;
    logic [35:0] rz;
    logic [21:0] rz14;
    logic [16:0] sat;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            amp_mem[wr_addr]  <= wr_amp;
            freq_mem[wr_addr] <= wr_freq;
            ph_mem[wr_addr]   <= wr_phase;
        end
        f1_reg <= freq_mem[rd_addr];
        p1_reg <= ph_mem[rd_addr];
        a1_reg <= amp_mem[rd_addr];
    end

    always_comb
    begin
        u3  = ph3_reg[31:16];
        x3  = u3[13:0];
        zc  = u3[14] ? (15'd16384 - {1'b0, x3}) : {1'b0, x3};
        zz  = z4_reg * z4_reg;
        t1  = 32'(15'd21024) - ((32'd2320 * 32'(z2_5_reg)) >> 14);
        rr  = 16'd51472 - 16'((t1 * 32'(z2_5_reg)) >> 14);
        rz  = 36'(r6_reg) * 36'(z6_reg);
        rz14 = rz[35:14];
        sat = (rz14 > 22'd32767) ? 17'd32767 : 17'(rz14);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            t_reg <= sample_time;
        pr2_reg <= f1_reg * t_reg;
        a2_reg  <= a1_reg;
        ph3_reg <= pr2_reg + p1_d_reg;
        a3_reg  <= a2_reg;
        z4_reg  <= zc;
        q4_reg  <= u3[15:14];
        a4_reg  <= a3_reg;
        z2_5_reg <= 16'(zz >> 14);
        z5_reg  <= z4_reg;
        q5_reg  <= q4_reg;
        a5_reg  <= a4_reg;
        r6_reg  <= rr;
        z6_reg  <= z5_reg;
        q6_reg  <= q5_reg;
        a6_reg  <= a5_reg;
        s7_reg  <= sat[15:0];
        q7_reg  <= q6_reg;
        a7_reg  <= a6_reg;
        prod_reg <= a7_reg * (q7_reg[1] ? -$signed({1'b0, s7_reg}) : $signed({1'b0, s7_reg}));
    end

    always_ff @(posedge clk)
    begin
        p1_d_reg <= p1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            vld_reg      <= {vld_reg[LAT-2:0], cmd.issue};
            prod_vld_reg <= vld_reg[LAT-1];
            if (cmd.clear)
                acc_reg <= '0;
            else if (prod_vld_reg)
                acc_reg <= acc_reg + sbe_pkg::SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            sum_value <= acc_reg;
    end

    assign stat.busy = (|vld_reg) | prod_vld_reg;

endmodule

### hdl/sbe_control.sv
// ----------------------------------------------------------------------------
// sbe_control
// sequencer for loads, evaluation sweeps and result handoff
// ----------------------------------------------------------------------------
module sbe_control #(
    parameter int IDX_W = 8,
    parameter int NUM_OSC = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_eval,
    input  logic [8:0]       active_count,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] rd_addr,
    output sbe_pkg::cmd_t    cmd,
    input  sbe_pkg::stat_t   stat
);

    localparam int CNT_W = IDX_W + 1;
    localparam int CW    = (CNT_W > 9) ? CNT_W : 9;

    sbe_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, lim_reg, lim_next;
    logic [CW-1:0] ac_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbe_pkg::ST_IDLE;
            cnt_reg   <= '0;
            lim_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
        end
    end

    assign rd_addr = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        ac_w       = CW'(active_count);
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lim_next   = lim_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            sbe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_eval)
                begin
                    cmd.clear = 1'b1;
                    cnt_next  = '0;
                    lim_next  = (ac_w > CW'(NUM_OSC)) ? CNT_W'(NUM_OSC) : CNT_W'(ac_w);
                    state_next = sbe_pkg::ST_RUN;
                end
            end
            sbe_pkg::ST_RUN:
            begin
                if (cnt_reg < lim_reg)
                begin
                    cmd.issue = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                    state_next = sbe_pkg::ST_DRAIN;
            end
            sbe_pkg::ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sbe_pkg::ST_OUT;
                end
            end
            sbe_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = sbe_pkg::ST_IDLE;
            end
            default: state_next = sbe_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> state_reg == sbe_pkg::ST_RUN) else $error("issue outside run");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !stat.busy) else $error("capture while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sbe_pkg::ST_RUN |-> cnt_reg <= lim_reg) else $error("count overrun");

endmodule

### hdl/sinusoid_bank_evaluator.sv
// ----------------------------------------------------------------------------
// sinusoid_bank_evaluator
// bank of oscillators summed as amplitude times sine at a given time
//
// channel   dir  fields
// s_axis    in   tuser: action; tdata: entry_index, amplitude, freq_step,
//                phase_offset, sample_time (120 bits)
// m_axis    out  tdata: sum_value (40 bits)
// cfg       in   active_count (9 bits)
//
// load: the entry is written when its beat is accepted. evaluate: result beat
// offered once the sweep has drained from the pipe, oscillator count capped at
// NUM_OSCILLATORS, one oscillator per cycle through the sine and multiply pipe.
// no clearing pass after reset; unwritten entries read undefined.
// input is held off while an evaluation or its result is pending.
// ----------------------------------------------------------------------------
module sinusoid_bank_evaluator #(
    parameter int NUM_OSCILLATORS = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // entry_index, amplitude, freq_step, phase_offset, sample_time
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // sum_value
    input  logic         cfg_wr_en,
    input  logic [8:0]   cfg_wr_data
);

    localparam int IDX_W = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;

    logic [8:0] active_count_reg;
    logic [IDX_W-1:0] rd_addr;
    sbe_pkg::cmd_t cmd;
    sbe_pkg::stat_t stat;
    logic wr_en;
    logic [7:0] idx_in;
    logic [8:0] idx_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_count_reg <= '0;
        else if (cfg_wr_en)
            active_count_reg <= cfg_wr_data;
    end

    assign idx_in  = s_axis_tdata[7:0];
    assign idx_ext = {1'b0, idx_in};
    assign wr_en   = s_axis_tvalid && s_axis_tready && !s_axis_tuser
                     && (32'(idx_ext) < 32'(NUM_OSCILLATORS));

    sbe_control #(.IDX_W(IDX_W), .NUM_OSC(NUM_OSCILLATORS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_eval(s_axis_tuser), .active_count(active_count_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .rd_addr(rd_addr), .cmd(cmd), .stat(stat)
    );

    sbe_datapath #(.IDX_W(IDX_W)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_addr(IDX_W'(idx_in)),
        .wr_amp(s_axis_tdata[23:8]), .wr_freq(s_axis_tdata[55:24]),
        .wr_phase(s_axis_tdata[87:56]),
        .rd_addr(rd_addr), .sample_time(s_axis_tdata[119:88]),
        .cmd(cmd), .stat(stat), .sum_value(m_axis_tdata)
    );

endmodule
